// ----- rtl/core/rbst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rbst_pkg
// Shared constants for the ray / box slab test pipeline.
// ---------------------------------------------------------------------------
package rbst_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NUM_AXES        = 3;

endpackage
`default_nettype wire

// ----- rtl/core/rbst_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rbst_div
// Pipelined restoring divider: floor(n * 2^FB / d), saturated to lim.
// One quotient bit per stage; saturation tracked with a sticky flag.
// ---------------------------------------------------------------------------
module rbst_div #(
  parameter int CW = rbst_pkg::COORD_WIDTH_DEF,
  parameter int FB = rbst_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [CW:0]   num,
  input  wire logic [CW-1:0] den,
  input  wire logic          neg,
  output logic      [CW-1:0] quo
);
  // num < 2^(CW+1); quotient integer part up to CW+1 bits, plus FB fraction
  localparam int QW    = CW + 1 + FB;
  localparam int STEPS = QW;

  logic [CW:0]   rem  [0:STEPS];
  logic [QW-1:0] nsh  [0:STEPS];
  logic [CW:0]   q    [0:STEPS];
  logic          sat  [0:STEPS];
  logic [CW-1:0] dd   [0:STEPS];
  logic          ng   [0:STEPS];

  // limit: 2^(CW-1) when negative, else 2^(CW-1)-1
  function automatic logic [CW:0] lim_of(input logic n);
    logic [CW:0] l;
    l = {2'b01, {(CW-1){1'b0}}};
    if (!n) l = l - 1'b1;
    return l;
  endfunction

  always_comb begin
    rem[0] = '0;
    nsh[0] = {num, {FB{1'b0}}};
    q[0]   = '0;
    sat[0] = 1'b0;
    dd[0]  = den;
    ng[0]  = neg;
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [CW+1:0] r2;
    logic [CW+1:0] diff;
    logic          ge;
    logic [CW+1:0] qn;
    assign r2   = {rem[s], nsh[s][QW-1]};
    assign diff = r2 - {2'b00, dd[s]};
    assign ge   = r2 >= {2'b00, dd[s]};
    assign qn   = {q[s], ge};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? diff[CW:0] : r2[CW:0];
        nsh[s+1] <= {nsh[s][QW-2:0], 1'b0};
        dd[s+1]  <= dd[s];
        ng[s+1]  <= ng[s];
        if (sat[s] || qn > {1'b0, lim_of(ng[s])}) begin
          sat[s+1] <= 1'b1;
          q[s+1]   <= lim_of(ng[s]);
        end else begin
          sat[s+1] <= 1'b0;
          q[s+1]   <= qn[CW:0];
        end
      end
    end
  end

  logic [CW:0] mag;
  assign mag = q[STEPS];
  assign quo = ng[STEPS] ? CW'(-mag) : mag[CW-1:0];
endmodule
`default_nettype wire

// ----- rtl/core/ray_box_slab_test_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ray_box_slab_test_core
// Ray line against axis-aligned box, slab method, fixed point.
// ---------------------------------------------------------------------------
//  channel | signals                        | direction
//  in      | in_valid / in_stall + 12 coords | into block
//  out     | out_valid / out_stall + hit     | out of block
//
// One transaction per cycle while the output is not blocked.
// Depth is set by the six bit-per-stage dividers (one quotient bit a stage).
// Reset clears only the valid bits; payload registers are not reset.
// A stall on out while out_valid is high freezes the whole pipe; in_stall follows it.
module ray_box_slab_test_core #(
  parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_x,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_y,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_z,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_x,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_y,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_z,
  input  wire logic signed [COORD_WIDTH-1:0] origin_x,
  input  wire logic signed [COORD_WIDTH-1:0] origin_y,
  input  wire logic signed [COORD_WIDTH-1:0] origin_z,
  input  wire logic signed [COORD_WIDTH-1:0] dir_x,
  input  wire logic signed [COORD_WIDTH-1:0] dir_y,
  input  wire logic signed [COORD_WIDTH-1:0] dir_z,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               hit
);
  import rbst_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DLAT = CW + 1 + FRAC_BITS;
  localparam int VLEN = DLAT + 4;

  logic en;
  logic [VLEN-1:0] vld;

  // input is stalled only when the output is blocked (valid and stalled)
  assign en       = !(out_stall && out_valid);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[VLEN-2:0], in_valid};
    end
  end

  logic signed [CW-1:0] lo  [NUM_AXES];
  logic signed [CW-1:0] hi  [NUM_AXES];
  logic signed [CW-1:0] org [NUM_AXES];
  logic signed [CW-1:0] dr  [NUM_AXES];
  assign lo  = '{box_min_x, box_min_y, box_min_z};
  assign hi  = '{box_max_x, box_max_y, box_max_z};
  assign org = '{origin_x, origin_y, origin_z};
  assign dr  = '{dir_x, dir_y, dir_z};

  // stage 1: differences, magnitudes, zero-direction checks
  logic [CW:0]   n0 [NUM_AXES];
  logic [CW:0]   n1 [NUM_AXES];
  logic [CW-1:0] dm [NUM_AXES];
  logic          ng0 [NUM_AXES];
  logic          ng1 [NUM_AXES];
  logic          z0 [NUM_AXES];
  logic          z1 [NUM_AXES];
  logic          dz [NUM_AXES];
  logic          axmiss [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_s1
    logic signed [CW:0] d0, d1;
    logic               dneg;
    assign d0   = (CW+1)'(lo[a]) - (CW+1)'(org[a]);
    assign d1   = (CW+1)'(hi[a]) - (CW+1)'(org[a]);
    assign dneg = dr[a][CW-1];
    always_ff @(posedge clk) begin
      if (en) begin
        n0[a]  <= d0[CW] ? -d0 : d0;
        n1[a]  <= d1[CW] ? -d1 : d1;
        ng0[a] <= (d0[CW] != dneg);
        ng1[a] <= (d1[CW] != dneg);
        z0[a]  <= (d0 == '0);
        z1[a]  <= (d1 == '0);
        dm[a]  <= dneg ? CW'(-dr[a]) : dr[a];
        dz[a]  <= (dr[a] == '0);
        axmiss[a] <= (dr[a] == '0) && ((org[a] < lo[a]) || (org[a] > hi[a]));
      end
    end
  end

  // dividers with side-band delay lines
  logic [CW-1:0] q0 [NUM_AXES];
  logic [CW-1:0] q1 [NUM_AXES];
  logic [DLAT-1:0] zd0 [NUM_AXES];
  logic [DLAT-1:0] zd1 [NUM_AXES];
  logic [DLAT-1:0] dzd [NUM_AXES];
  logic [DLAT-1:0] msd [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_div
    logic [CW-1:0] dsafe;
    assign dsafe = dz[a] ? CW'(1) : dm[a];
    rbst_div #(.CW(CW), .FB(FRAC_BITS)) u_d0 (
      .clk(clk), .en(en), .num(n0[a]), .den(dsafe), .neg(ng0[a]), .quo(q0[a]));
    rbst_div #(.CW(CW), .FB(FRAC_BITS)) u_d1 (
      .clk(clk), .en(en), .num(n1[a]), .den(dsafe), .neg(ng1[a]), .quo(q1[a]));
    always_ff @(posedge clk) begin
      if (en) begin
        zd0[a] <= {zd0[a][DLAT-2:0], z0[a]};
        zd1[a] <= {zd1[a][DLAT-2:0], z1[a]};
        dzd[a] <= {dzd[a][DLAT-2:0], dz[a]};
        msd[a] <= {msd[a][DLAT-2:0], axmiss[a]};
      end
    end
  end

  // stage 2: per-axis ordering
  localparam logic signed [CW-1:0] TMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] TMAX = {1'b0, {(CW-1){1'b1}}};

  logic signed [CW-1:0] ent [NUM_AXES];
  logic signed [CW-1:0] ext [NUM_AXES];
  logic                 amiss;

  always_ff @(posedge clk) begin
    if (en) begin
      amiss <= msd[0][DLAT-1] | msd[1][DLAT-1] | msd[2][DLAT-1];
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_ord
    logic signed [CW-1:0] t0, t1;
    assign t0 = zd0[a][DLAT-1] ? '0 : $signed(q0[a]);
    assign t1 = zd1[a][DLAT-1] ? '0 : $signed(q1[a]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (dzd[a][DLAT-1]) begin
          ent[a] <= TMIN;
          ext[a] <= TMAX;
        end else if (t0 > t1) begin
          ent[a] <= t1;
          ext[a] <= t0;
        end else begin
          ent[a] <= t0;
          ext[a] <= t1;
        end
      end
    end
  end

  // stage 3: max entry, min exit
  logic signed [CW-1:0] emax, xmin;
  logic                 miss3;
  logic signed [CW-1:0] e01, x01;
  assign e01 = (ent[0] > ent[1]) ? ent[0] : ent[1];
  assign x01 = (ext[0] < ext[1]) ? ext[0] : ext[1];

  always_ff @(posedge clk) begin
    if (en) begin
      emax  <= (e01 > ent[2]) ? e01 : ent[2];
      xmin  <= (x01 < ext[2]) ? x01 : ext[2];
      miss3 <= amiss;
    end
  end

  // stage 4: output register
  always_ff @(posedge clk) begin
    if (en) begin
      hit <= !(miss3 || (xmin <= emax));
    end
  end

  assign out_valid = vld[VLEN-1];
endmodule
`default_nettype wire

// ----- rtl/core/rbst_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rbst_checker
// Port-level checks for the slab test core.
// ---------------------------------------------------------------------------
module rbst_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic hit
);
  // input only stalls when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without blocked output");

  // blocked result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hit)))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");
endmodule

bind ray_box_slab_test_core rbst_checker u_rbst_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .hit(hit));
`default_nettype wire
